// File: hdl/sltfr_pkg.sv
// Shared types, constants and register codes for the sync/length/type frame receiver.
package sltfr_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;

	localparam logic [7:0]  PAYLOAD_LEN_RST   = 8'd16;
	localparam logic [7:0]  FRAME_TYPE_RST    = 8'd1;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd50;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int MID_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAYLOAD_LEN   = 2'd0,
		REG_FRAME_TYPE    = 2'd1,
		REG_TIMEOUT_TICKS = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		EV_PAYLOAD  = 2'd0,
		EV_TIMEOUT  = 2'd1,
		EV_BAD_LEN  = 2'd2,
		EV_BAD_TYPE = 2'd3
	} ev_kind_t;

	typedef struct packed {
		logic [7:0]  payload_len;
		logic [7:0]  frame_type;
		logic [15:0] timeout_ticks;
	} cfg_t;

	// Classified input beat handed from the front to the back
	typedef struct packed {
		logic       is_tick;
		logic [7:0] data;
		logic       is_sync1;
		logic       is_sync2;
		logic       len_ok;
		logic       type_ok;
	} item_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [7:0] data;
		logic       last;
	} result_t;

	localparam int ITEM_W   = $bits(item_t);
	localparam int RESULT_W = $bits(result_t);

endpackage

// File: hdl/sltfr_queue.sv
// Small first-in first-out queue with a register array and push/pop counters.
module sltfr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/sltfr_front.sv
// Front stage: accept input beats, classify them against the sync bytes and configuration.
module sltfr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sltfr_pkg::cfg_t      cfg,
	input  logic                 push,
	output logic                 full,
	input  logic                 req_type,
	input  logic [7:0]           rx_byte,
	output logic                 mid_push,
	output sltfr_pkg::item_t     mid_item,
	input  logic                 mid_full
);

	logic             valid_s1;
	sltfr_pkg::item_t item_s1;
	sltfr_pkg::item_t item_d;
	logic             take;
	logic [8:0]       exp_len;

	// Stage is free when empty or when its beat moves on this cycle
	assign full     = valid_s1 && mid_full;
	assign take     = push && !full;
	assign mid_push = valid_s1 && !mid_full;
	assign mid_item = item_s1;

	// Classify the beat; a length of 255 never matches
	always_comb begin
		exp_len          = {1'b0, cfg.payload_len} + 9'd1;
		item_d.is_tick   = req_type;
		item_d.data      = rx_byte;
		item_d.is_sync1  = (rx_byte == sltfr_pkg::SYNC_FIRST);
		item_d.is_sync2  = (rx_byte == sltfr_pkg::SYNC_SECOND);
		item_d.len_ok    = ({1'b0, rx_byte} == exp_len);
		item_d.type_ok   = (rx_byte == cfg.frame_type);
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (mid_push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

// File: hdl/sltfr_back.sv
// Back end: frame state machine that turns classified beats into result events.
module sltfr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sltfr_pkg::cfg_t      cfg,
	input  logic                 mid_empty,
	input  sltfr_pkg::item_t     mid_item,
	output logic                 mid_pop,
	input  logic                 out_full,
	output logic                 out_push,
	output sltfr_pkg::result_t   out_res
);

	typedef enum logic [5:0] {
		PH_HUNT    = 6'b000001,
		PH_SYNC2   = 6'b000010,
		PH_LEN     = 6'b000100,
		PH_TYPE    = 6'b001000,
		PH_DRAIN   = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} phase_t;

	phase_t      phase_q,      phase_d;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic [15:0] wait_ticks_q, wait_ticks_d;
	logic        drain_kind_q, drain_kind_d;
	logic        go;
	logic        emit;
	sltfr_pkg::result_t res;
	logic        len_zero;
	logic        final_byte;

	// Take a beat only when a result has room to go
	assign go       = !mid_empty && !out_full;
	assign mid_pop  = go;
	assign out_push = go && emit;
	assign out_res  = res;
	assign len_zero   = (cfg.payload_len == '0);
	assign final_byte = (bytes_left_q == 8'd1);

	// Next-state and event decode
	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		wait_ticks_d = wait_ticks_q;
		drain_kind_d = drain_kind_q;
		emit         = 1'b0;
		res.kind     = sltfr_pkg::EV_PAYLOAD;
		res.data     = '0;
		res.last     = 1'b0;
		if (mid_item.is_tick) begin
			if (phase_q != PH_HUNT) begin
				if (wait_ticks_q >= cfg.timeout_ticks) begin
					phase_d      = PH_HUNT;
					wait_ticks_d = '0;
					bytes_left_d = '0;
					emit         = 1'b1;
					res.kind     = sltfr_pkg::EV_TIMEOUT;
				end else begin
					wait_ticks_d = wait_ticks_q + 16'd1;
				end
			end
		end else begin
			wait_ticks_d = '0;
			case (phase_q)
				PH_SYNC2: begin
					phase_d = mid_item.is_sync2 ? PH_LEN : PH_HUNT;
				end
				PH_LEN: begin
					if (!mid_item.len_ok) begin
						if (mid_item.data == '0) begin
							phase_d  = PH_HUNT;
							emit     = 1'b1;
							res.kind = sltfr_pkg::EV_BAD_LEN;
						end else begin
							bytes_left_d = mid_item.data;
							drain_kind_d = 1'b0;
							phase_d      = PH_DRAIN;
						end
					end else begin
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					if (len_zero) begin
						phase_d = PH_HUNT;
						if (!mid_item.type_ok) begin
							emit     = 1'b1;
							res.kind = sltfr_pkg::EV_BAD_TYPE;
						end
					end else begin
						bytes_left_d = cfg.payload_len;
						drain_kind_d = !mid_item.type_ok;
						phase_d      = mid_item.type_ok ? PH_PAYLOAD : PH_DRAIN;
					end
				end
				PH_DRAIN: begin
					bytes_left_d = bytes_left_q - 8'd1;
					if (final_byte) begin
						phase_d  = PH_HUNT;
						emit     = 1'b1;
						res.kind = drain_kind_q ? sltfr_pkg::EV_BAD_TYPE
						                        : sltfr_pkg::EV_BAD_LEN;
					end
				end
				PH_PAYLOAD: begin
					bytes_left_d = bytes_left_q - 8'd1;
					emit         = 1'b1;
					res.data     = mid_item.data;
					res.last     = final_byte;
					if (final_byte) begin
						phase_d = PH_HUNT;
					end
				end
				default: begin
					// Hunting, and any stray code behaves as hunting
					phase_d = mid_item.is_sync1 ? PH_SYNC2 : PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			bytes_left_q <= '0;
			wait_ticks_q <= '0;
			drain_kind_q <= 1'b0;
		end else if (go) begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			wait_ticks_q <= wait_ticks_d;
			drain_kind_q <= drain_kind_d;
		end
	end

endmodule

// File: hdl/sync_length_type_frame_receiver.sv
// Top level: configuration registers, front classifier, beat queue, frame back end, result queue.
// A result reaches the result ports through the front register, the mid queue and the result queue.
// Throughput: one input beat per cycle while no queue is full; the back end's one-beat-per-cycle state machine sets it.
// The front stalls only when the mid queue is full; the back stalls only when the result queue is.
// Reset (arst_n low, asynchronous): queues empty, hunting for the first sync byte, counters zero,
// registers at payload_len 16, frame_type 1, timeout_ticks 50.
module sync_length_type_frame_receiver #(
	parameter int MID_DEPTH = sltfr_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH = sltfr_pkg::OUT_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            req_type,
	input  logic [7:0]                      rx_byte,
	output logic                            empty,
	input  logic                            pop,
	output logic [1:0]                      event_kind,
	output logic [7:0]                      payload_byte,
	output logic                            last_byte,
	input  logic                            cfg_we,
	input  logic [sltfr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sltfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	sltfr_pkg::cfg_t    cfg_q;
	logic               mid_push;
	logic               mid_pop;
	logic               mid_full;
	logic               mid_empty;
	sltfr_pkg::item_t   mid_wr_item;
	sltfr_pkg::item_t   mid_rd_item;
	logic [sltfr_pkg::ITEM_W-1:0] mid_rdata;
	logic               out_push;
	logic               out_full;
	sltfr_pkg::result_t out_res;
	sltfr_pkg::result_t head_res;
	logic [sltfr_pkg::RESULT_W-1:0] out_rdata;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.payload_len   <= sltfr_pkg::PAYLOAD_LEN_RST;
			cfg_q.frame_type    <= sltfr_pkg::FRAME_TYPE_RST;
			cfg_q.timeout_ticks <= sltfr_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			case (sltfr_pkg::cfg_idx_t'(cfg_idx))
				sltfr_pkg::REG_PAYLOAD_LEN:   cfg_q.payload_len   <= cfg_wdata[7:0];
				sltfr_pkg::REG_FRAME_TYPE:    cfg_q.frame_type    <= cfg_wdata[7:0];
				sltfr_pkg::REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	sltfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.full     (full),
		.req_type (req_type),
		.rx_byte  (rx_byte),
		.mid_push (mid_push),
		.mid_item (mid_wr_item),
		.mid_full (mid_full)
	);

	sltfr_queue #(
		.WIDTH (sltfr_pkg::ITEM_W),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wr_item),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign mid_rd_item = sltfr_pkg::item_t'(mid_rdata);

	sltfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_empty (mid_empty),
		.mid_item  (mid_rd_item),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_res   (out_res)
	);

	sltfr_queue #(
		.WIDTH (sltfr_pkg::RESULT_W),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	// Present the oldest result
	assign head_res     = sltfr_pkg::result_t'(out_rdata);
	assign event_kind   = head_res.kind;
	assign payload_byte = head_res.data;
	assign last_byte    = head_res.last;

endmodule

// File: hdl/sltfr_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
module sltfr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             push,
	input logic                             full,
	input logic                             req_type,
	input logic [7:0]                       rx_byte,
	input logic                             empty,
	input logic                             pop,
	input logic [1:0]                       event_kind,
	input logic [7:0]                       payload_byte,
	input logic                             last_byte,
	input logic                             cfg_we,
	input logic [sltfr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input logic [sltfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	// Non-payload events carry no byte and no last mark
	a_event_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind != sltfr_pkg::EV_PAYLOAD) |-> (payload_byte == 8'd0 && !last_byte))
		else $error("non-payload event carries data or last mark");

	// A last mark only ever closes a payload byte
	a_last_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_byte) |-> (event_kind == sltfr_pkg::EV_PAYLOAD))
		else $error("last mark on a non-payload event");

	// A waiting result holds until it is taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(event_kind) && $stable(payload_byte)
			&& $stable(last_byte)))
		else $error("waiting result changed before pop");

endmodule

bind sync_length_type_frame_receiver sltfr_checker u_sltfr_checker (.*);
